// ----- rtl/krt_pkg.sv -----
// Shared types, constants and helpers for the keyed record table.
// No dependencies; used by krt_ctrl, krt_dpath and keyed_record_table_unit.
package krt_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 27;
  localparam int GRADE_W   = 7;
  localparam int OCC_W     = 6;
  localparam int REC_W     = KEY_W + 2 * GRADE_W;

  localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(100);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

  function automatic logic [GRADE_W-1:0] sat_grade(input logic [GRADE_W-1:0] g);
    return (g > GRADE_MAX) ? GRADE_MAX : g;
  endfunction

endpackage

// ----- rtl/krt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/krt_ctrl.sv -----
// Controller FSM for the keyed record table: accept, scan, drain, execute, deliver.
// Depends on krt_pkg.
module krt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  krt_pkg::dp_sts_t sts,
  output krt_pkg::dp_cmd_t cmd
);
  import krt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_EXEC;
      S_EXEC:  state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.issue = (state == S_SCAN);
    cmd.exec  = (state == S_EXEC);
  end

endmodule

// ----- rtl/krt_dpath.sv -----
// Datapath for the keyed record table: record RAM, slot valid bits, scan
// compare, operation execute and result registers. Depends on krt_pkg, krt_ram.
module krt_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  krt_pkg::dp_cmd_t              cmd,
  output krt_pkg::dp_sts_t              sts,
  input  krt_pkg::kind_t                kind,
  input  logic [krt_pkg::KEY_W-1:0]     key,
  input  logic [krt_pkg::GRADE_W-1:0]   grade_first,
  input  logic [krt_pkg::GRADE_W-1:0]   grade_second,
  output krt_pkg::status_t              status,
  output logic [krt_pkg::GRADE_W-1:0]   stored_grade_first,
  output logic [krt_pkg::GRADE_W-1:0]   stored_grade_second,
  output logic [krt_pkg::OCC_W-1:0]     occupied_count
);
  import krt_pkg::*;

  // operation held for the whole scan
  kind_t              op_kind;
  logic [KEY_W-1:0]   op_key;
  logic [GRADE_W-1:0] op_g1;
  logic [GRADE_W-1:0] op_g2;

  logic [IDX_W-1:0]   scan_addr;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_vld;

  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic [GRADE_W-1:0] match_g1;
  logic [GRADE_W-1:0] match_g2;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   used_slots;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [REC_W-1:0]   ram_wdata;
  logic [REC_W-1:0]   ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [GRADE_W-1:0] rd_g1;
  logic [GRADE_W-1:0] rd_g2;
  logic               slot_used;
  logic               hit;

  status_t            res_status;
  logic [GRADE_W-1:0] res_g1;
  logic [GRADE_W-1:0] res_g2;
  logic               set_v;
  logic               clr_v;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[REC_W-1 -: KEY_W];
  assign rd_g1  = ram_rdata[2*GRADE_W-1 -: GRADE_W];
  assign rd_g2  = ram_rdata[GRADE_W-1:0];

  assign slot_used = valid[cmp_idx];
  assign hit       = cmp_vld && slot_used && (rd_key == op_key) && (op_key != '0);

  assign sts.scan_last = (scan_addr == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= kind;
      op_key  <= key;
      op_g1   <= sat_grade(grade_first);
      op_g2   <= sat_grade(grade_second);
    end
    if (cmd.issue) begin
      cmp_idx <= scan_addr;
    end
    if (hit && !match_found) begin
      match_idx <= cmp_idx;
      match_g1  <= rd_g1;
      match_g2  <= rd_g2;
    end
    if (cmp_vld && !slot_used && !free_found) begin
      free_idx <= cmp_idx;
    end
    if (cmd.exec) begin
      status              <= res_status;
      stored_grade_first  <= res_g1;
      stored_grade_second <= res_g2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr   <= '0;
      cmp_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      cmp_vld <= cmd.issue;
      if (cmd.load) begin
        scan_addr   <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else begin
        if (cmd.issue) scan_addr <= scan_addr + 1'b1;
        if (hit) match_found <= 1'b1;
        if (cmp_vld && !slot_used) free_found <= 1'b1;
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_g1     = '0;
    res_g2     = '0;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = {op_key, op_g1, op_g2};
    if (op_kind == KIND_INSERT) begin
      if (used_slots >= CNT_W'(ENTRIES)) begin
        res_status = ST_FULL;
      end else if (op_key == '0 || match_found) begin
        res_status = ST_DUP;
      end else if (!free_found) begin
        res_status = ST_FULL;
      end else begin
        set_v  = cmd.exec;
        ram_we = cmd.exec;
        res_g1 = op_g1;
        res_g2 = op_g2;
      end
    end else if (used_slots == '0) begin
      res_status = ST_EMPTY;
    end else if (!match_found) begin
      res_status = ST_NOTFOUND;
    end else begin
      case (op_kind)
        KIND_LOOKUP: begin
          res_g1 = match_g1;
          res_g2 = match_g2;
        end
        KIND_UPDATE: begin
          ram_we    = cmd.exec;
          ram_waddr = match_idx;
          res_g1    = op_g1;
          res_g2    = op_g2;
        end
        default: begin
          clr_v = cmd.exec;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used_slots <= '0;
    end else begin
      if (set_v) begin
        valid[free_idx] <= 1'b1;
        used_slots      <= used_slots + 1'b1;
      end
      if (clr_v) begin
        valid[match_idx] <= 1'b0;
        used_slots       <= used_slots - 1'b1;
      end
    end
  end

  assign occupied_count = OCC_W'(used_slots);

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used_slots))
    else $error("occupied count out of step with slot valid bits");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !cmp_vld && !cmd.issue)
    else $error("execute while scan compare still pending");

  a_free_slot_exists: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_kind == KIND_INSERT && used_slots < CNT_W'(ENTRIES)) |-> free_found)
    else $error("insert on non-full table found no free slot");

  a_set_once: assert property (@(posedge clk) disable iff (rst)
    set_v |=> valid[$past(free_idx)])
    else $error("inserted slot not marked valid");

endmodule

// ----- rtl/keyed_record_table_unit.sv -----
// Keyed record table: content-addressable store of keyed records with two grades.
// Depends on krt_pkg, krt_ctrl, krt_dpath (which holds krt_ram).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per beat: kind
//   (insert, lookup, update, delete), key and two grades in tenths; grades
//   above 100 are stored as 100. Output channel (out_valid/out_ready) returns
//   one beat per operation: status, the grades of the record looked up,
//   inserted or updated (zero otherwise) and the number of occupied slots.
//   Each operation scans the record RAM one slot per cycle over all ENTRIES
//   slots, then passes through a drain state and an execute state. One
//   operation is in flight at a time: a new input beat is accepted only after
//   the previous result has been taken. The scan through the single RAM read
//   port sets the time each operation takes.
//   While out_valid waits for out_ready the result holds and in_ready stays low.
//   Reset (rst, synchronous) clears all slot valid bits and the count, so the
//   table is empty at once; there is no clearing pass.
module keyed_record_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  krt_pkg::kind_t                kind,
  input  logic [krt_pkg::KEY_W-1:0]     key,
  input  logic [krt_pkg::GRADE_W-1:0]   grade_first,
  input  logic [krt_pkg::GRADE_W-1:0]   grade_second,
  output logic                          out_valid,
  input  logic                          out_ready,
  output krt_pkg::status_t              status,
  output logic [krt_pkg::GRADE_W-1:0]   stored_grade_first,
  output logic [krt_pkg::GRADE_W-1:0]   stored_grade_second,
  output logic [krt_pkg::OCC_W-1:0]     occupied_count
);
  import krt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  krt_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .kind                (kind),
    .key                 (key),
    .grade_first         (grade_first),
    .grade_second        (grade_second),
    .status              (status),
    .stored_grade_first  (stored_grade_first),
    .stored_grade_second (stored_grade_second),
    .occupied_count      (occupied_count)
  );

endmodule
